// File: src/mbr_pkg.sv
// ============================================================================
// mbr_pkg : shared types and constants of the bitmap colour expansion blitter
// Holds the register index codes, the configuration bundle and the event
// record that travels from the byte classifier to the result sequencer.
// ============================================================================
package mbr_pkg;

    // Clamp applied to the programmed bitmap width
    localparam int MAX_SIDE = 255;

    // Event slots per byte: one per pixel bit, plus the row-end span
    localparam int NUM_EV  = 9;
    localparam int EV_SPAN = 8;
    localparam int EV_W    = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_FG_COLOR     = 3'd0,
        REG_CLEAR_COLOR  = 3'd1,
        REG_TRANSPARENT  = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4,
        REG_ORIGIN_X     = 3'd5,
        REG_ORIGIN_Y     = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [15:0] FG_RESET     = 16'hffff;
    localparam logic [15:0] CLEAR_RESET  = 16'h0000;
    localparam logic [7:0]  WIDTH_RESET  = 8'd8;
    localparam logic [7:0]  HEIGHT_RESET = 8'd8;

    // Live configuration
    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] clear_color;
        logic        transparent;
        logic [7:0]  image_width;
        logic [7:0]  image_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } cfg_t;

    // Results one byte causes, in bitmap coordinates
    typedef struct packed {
        logic [NUM_EV-1:0]       mask;    // slot holds a result
        logic [NUM_EV-1:0]       fg_sel;  // foreground colour, else background
        logic [NUM_EV-1:0][7:0]  xs;      // first column
        logic [NUM_EV-1:0][7:0]  xe;      // last column, inclusive
        logic [7:0]              row;
        logic                    done;    // byte ends the bitmap
    } ev_entry_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// File: src/mbr_fifo.sv
// ============================================================================
// mbr_fifo : two-entry event queue
// Decouples the byte classifier from the result sequencer so that either
// side may stall without holding up the other.
// ============================================================================
module mbr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mbr_pkg::ev_entry_t push_entry,
    input  logic               pop,
    output mbr_pkg::ev_entry_t head,
    output mbr_pkg::q_status_t status
);

    mbr_pkg::ev_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    // Qualify the requests
    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

// File: src/mbr_front.sv
// ============================================================================
// mbr_front : byte classifier
// Accepts one bitmap byte a cycle while the queue has room, walks its eight
// pixels against the row width, tracks the pending span and the row
// position, and queues the results the byte causes as one event record.
// ============================================================================
module mbr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  mbr_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         bitmap_byte,
    input  logic               q_full,
    output logic               push,
    output mbr_pkg::ev_entry_t entry
);

    logic [7:0] column_count_reg, column_count_next;
    logic [7:0] row_count_reg, row_count_next;
    logic       run_open_reg, run_open_next;
    logic [7:0] run_begin_reg, run_begin_next;
    logic [7:0] w;
    logic       accept;

    // Clamp the width
    assign w = (cfg.image_width > mbr_pkg::MAX_SIDE) ? 8'(mbr_pkg::MAX_SIDE)
                                                      : cfg.image_width;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Walk the pixels and work out the row end
    always_comb
    begin
        logic [8:0] col;
        logic [8:0] row_inc;
        logic       open;
        logic [7:0] begin_col;
        logic       pix;

        open      = run_open_reg && cfg.transparent;
        begin_col = run_begin_reg;
        entry     = '0;
        entry.row = row_count_reg;

        for (int b = 0; b < 8; b++)
        begin
            col = {1'b0, column_count_reg} + 9'(b);
            pix = bitmap_byte[7 - b];
            if (col < {1'b0, w})
            begin
                if (!cfg.transparent)
                begin
                    entry.mask[b]   = 1'b1;
                    entry.fg_sel[b] = pix;
                    entry.xs[b]     = col[7:0];
                    entry.xe[b]     = col[7:0];
                end
                else if (pix && !open)
                begin
                    open      = 1'b1;
                    begin_col = col[7:0];
                end
                else if (!pix && open)
                begin
                    entry.mask[b]   = 1'b1;
                    entry.fg_sel[b] = 1'b1;
                    entry.xs[b]     = begin_col;
                    entry.xe[b]     = col[7:0] - 8'd1;
                    open            = 1'b0;
                end
            end
        end

        row_inc           = {1'b0, row_count_reg} + 9'd1;
        column_count_next = column_count_reg + 8'd8;
        row_count_next    = row_count_reg;

        if (({1'b0, column_count_reg} + 9'd8) >= {1'b0, w})
        begin
            // Close a span that reaches the row end, drop one past the width
            if (open && (begin_col < w))
            begin
                entry.mask[mbr_pkg::EV_SPAN]   = 1'b1;
                entry.fg_sel[mbr_pkg::EV_SPAN] = 1'b1;
                entry.xs[mbr_pkg::EV_SPAN]     = begin_col;
                entry.xe[mbr_pkg::EV_SPAN]     = w - 8'd1;
            end
            open              = 1'b0;
            column_count_next = 8'd0;
            if (row_inc >= {1'b0, cfg.image_height})
            begin
                row_count_next = 8'd0;
                entry.done     = 1'b1;
            end
            else
            begin
                row_count_next = row_inc[7:0];
            end
        end

        run_open_next  = open;
        run_begin_next = begin_col;
    end

    // Queue only bytes that cause results
    assign push = accept && (entry.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 8'd0;
            row_count_reg    <= 8'd0;
            run_open_reg     <= 1'b0;
            run_begin_reg    <= 8'd0;
        end
        else if (accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            run_open_reg     <= run_open_next;
            run_begin_reg    <= run_begin_next;
        end
    end

endmodule

// File: src/mbr_back.sv
// ============================================================================
// mbr_back : result sequencer
// Takes the event record at the queue head, issues its results lowest slot
// first, one a cycle unless the output stalls, into the output register, and
// pops the record after its last result.
// ============================================================================
module mbr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mbr_pkg::cfg_t      cfg,
    input  mbr_pkg::ev_entry_t head,
    input  logic               head_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        x_start,
    output logic [15:0]        x_end,
    output logic [15:0]        row_y,
    output logic [15:0]        pixel_color,
    output logic               last_of_item,
    output logic               image_done
);

    logic [mbr_pkg::NUM_EV-1:0] issued_reg, issued_next;
    logic [mbr_pkg::NUM_EV-1:0] remaining, ev_bit;
    logic [mbr_pkg::EV_W-1:0]   ev_idx;
    logic                       advance, take, is_last;

    logic        out_valid_reg;
    logic [15:0] x_start_reg, x_end_reg, row_y_reg, pixel_color_reg;
    logic        last_reg, done_reg;

    // Pick the lowest pending slot
    assign remaining = head.mask & ~issued_reg;
    assign ev_bit    = remaining & (~remaining + 1'b1);

    always_comb
    begin
        ev_idx = '0;
        for (int i = mbr_pkg::NUM_EV - 1; i >= 0; i--)
        begin
            if (ev_bit[i])
            begin
                ev_idx = mbr_pkg::EV_W'(i);
            end
        end
    end

    assign advance = !out_valid_reg || !out_stall;
    assign take    = advance && head_valid;
    assign is_last = (remaining & ~ev_bit) == '0;
    assign pop     = take && is_last;

    // Mark issued slots, clear on pop
    always_comb
    begin
        issued_next = issued_reg;
        if (take)
        begin
            issued_next = is_last ? '0 : (issued_reg | ev_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            issued_reg <= issued_next;
            if (advance)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_start_reg     <= cfg.origin_x + {8'd0, head.xs[ev_idx]};
            x_end_reg       <= cfg.origin_x + {8'd0, head.xe[ev_idx]};
            row_y_reg       <= cfg.origin_y + {8'd0, head.row};
            pixel_color_reg <= head.fg_sel[ev_idx] ? cfg.fg_color : cfg.clear_color;
            last_reg        <= is_last;
            done_reg        <= is_last && head.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_start      = x_start_reg;
    assign x_end        = x_end_reg;
    assign row_y        = row_y_reg;
    assign pixel_color  = pixel_color_reg;
    assign last_of_item = last_reg;
    assign image_done   = done_reg;

endmodule

// File: src/mono_bitmap_to_rgb565_spans.sv
// ============================================================================
// mono_bitmap_to_rgb565_spans : one-bit bitmap to RGB565 pixel/span blitter
// Expands a monochrome bitmap, one byte per transaction, into RGB565
// pixel results (opaque mode) or spans of set pixels (transparent mode).
// ============================================================================
// The block issues one result per clock on the output channel while out_stall
// is low. A byte yields up to eight results in opaque mode, and in transparent
// mode one per span closed, at most five (four closed inside the byte plus the
// row-end span). Bytes that cause no result are not queued. Each result is
// registered first in the event queue and then in the output register. The
// input side takes one byte per clock while the two-entry event queue between
// classifier and sequencer has room, so sustained rate is set by the
// sequencer's one-result-per-cycle output register. Configuration writes are
// always taken (cfg_ready stays high) and must be issued only when no
// transaction is in flight. No clearing pass is needed after reset.
module mono_bitmap_to_rgb565_spans (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  bitmap_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] x_start,
    output logic [15:0] x_end,
    output logic [15:0] row_y,
    output logic [15:0] pixel_color,
    output logic        last_of_item,
    output logic        image_done
);

    mbr_pkg::cfg_t      cfg_reg;
    mbr_pkg::ev_entry_t push_entry, head;
    mbr_pkg::q_status_t q_status;
    logic               push, pop;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color     <= mbr_pkg::FG_RESET;
            cfg_reg.clear_color  <= mbr_pkg::CLEAR_RESET;
            cfg_reg.transparent  <= 1'b0;
            cfg_reg.image_width  <= mbr_pkg::WIDTH_RESET;
            cfg_reg.image_height <= mbr_pkg::HEIGHT_RESET;
            cfg_reg.origin_x     <= 16'd0;
            cfg_reg.origin_y     <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mbr_pkg::reg_idx_t'(cfg_index))
                mbr_pkg::REG_FG_COLOR:     cfg_reg.fg_color     <= cfg_data;
                mbr_pkg::REG_CLEAR_COLOR:  cfg_reg.clear_color  <= cfg_data;
                mbr_pkg::REG_TRANSPARENT:  cfg_reg.transparent  <= cfg_data[0];
                mbr_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[7:0];
                mbr_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[7:0];
                mbr_pkg::REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data;
                mbr_pkg::REG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Classify bytes
    mbr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bitmap_byte (bitmap_byte),
        .q_full      (q_status.full),
        .push        (push),
        .entry       (push_entry)
    );

    // Hold pending event records
    mbr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Issue results
    mbr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (q_status.valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x_start      (x_start),
        .x_end        (x_end),
        .row_y        (row_y),
        .pixel_color  (pixel_color),
        .last_of_item (last_of_item),
        .image_done   (image_done)
    );

`ifndef SYNTHESIS
    // End of bitmap only on the final result of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_done) |-> last_of_item)
        else $error("image_done without last_of_item");

    // Opaque results are single pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cfg_reg.transparent) |-> (x_start == x_end))
        else $error("opaque result wider than one pixel");

    // Sequencer pops only a filled queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("pop from empty event queue");

    // A stalled classifier queues nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full event queue");
`endif

endmodule

// File: verif/mono_bitmap_to_rgb565_spans_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// mono_bitmap_to_rgb565_spans_tb : self-checking bench for the bitmap blitter
// Feeds bitmap bytes through a bursty sender, stalls the result side on a
// changing pattern and checks every pixel or span against a local model of
// the expansion. The registers are reprogrammed between phases, including
// mid-row width and height changes, zero sizes and wrapping origins.
// ============================================================================
module mono_bitmap_to_rgb565_spans_tb;

    localparam int RANDOM_ITEMS = 270;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    // One pixel or span as the block should paint it
    typedef struct packed {
        logic [15:0] xs;
        logic [15:0] xe;
        logic [15:0] y;
        logic [15:0] color;
        logic        last;
        logic        done;
    } paint_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = mbr_pkg::REG_FG_COLOR;
    logic [15:0] cfg_data     = 16'h0000;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  bitmap_byte  = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [15:0] x_start;
    logic [15:0] x_end;
    logic [15:0] row_y;
    logic [15:0] pixel_color;
    logic        last_of_item;
    logic        image_done;

    // Bytes waiting to be sent and paint results still owed by the block
    logic [7:0]  bitmap_q[$];
    paint_t      paint_q[$];

    // Model copy of the registers and of the raster position
    mbr_pkg::cfg_t shadow = '{fg_color: mbr_pkg::FG_RESET,
                              clear_color: mbr_pkg::CLEAR_RESET, transparent: 1'b0,
                              image_width: mbr_pkg::WIDTH_RESET,
                              image_height: mbr_pkg::HEIGHT_RESET,
                              origin_x: 16'h0000, origin_y: 16'h0000};
    int          col_pos    = 0;
    int          row_pos    = 0;
    logic        span_open  = 1'b0;
    int          span_from  = 0;

    int          mismatch_cnt = 0;
    int          result_cnt   = 0;
    int          cycle_cnt    = 0;
    int          burst_left   = 1;
    int          gap_left     = 0;
    int          stall_mode   = 0;
    int          stall_left   = 0;
    int          stall_tick   = 0;

    mono_bitmap_to_rgb565_spans i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .bitmap_byte  (bitmap_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x_start      (x_start),
        .x_end        (x_end),
        .row_y        (row_y),
        .pixel_color  (pixel_color),
        .last_of_item (last_of_item),
        .image_done   (image_done)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Build one result in screen coordinates on the current row
    function automatic paint_t make_paint(input int xs, input int xe, input logic [15:0] color);
        paint_t p;
        p.xs    = shadow.origin_x + xs[15:0];
        p.xe    = shadow.origin_x + xe[15:0];
        p.y     = shadow.origin_y + row_pos[15:0];
        p.color = color;
        p.last  = 1'b0;
        p.done  = 1'b0;
        return p;
    endfunction

    // Expand one accepted byte into the pixels or spans it completes
    function automatic void expand_byte(input logic [7:0] bits);
        int     w;
        int     col;
        int     b;
        int     i;
        logic   image_end;
        paint_t p;
        paint_t res[$];
        w = (shadow.image_width > mbr_pkg::MAX_SIDE) ? mbr_pkg::MAX_SIDE
                                                     : shadow.image_width;
        image_end = 1'b0;
        if (!shadow.transparent)
            span_open = 1'b0;
        for (b = 0; b < 8; b++)
        begin
            col = col_pos + b;
            if (col < w)
            begin
                if (!shadow.transparent)
                    res.push_back(make_paint(col, col,
                                             bits[7-b] ? shadow.fg_color : shadow.clear_color));
                else if (bits[7-b] && !span_open)
                begin
                    span_open = 1'b1;
                    span_from = col;
                end
                else if (!bits[7-b] && span_open)
                begin
                    res.push_back(make_paint(span_from, col - 1, shadow.fg_color));
                    span_open = 1'b0;
                end
            end
        end
        // Close the row: flush a pending span that still lies inside the width
        if (col_pos + 8 >= w)
        begin
            if (span_open)
            begin
                if (span_from < w && w > 0)
                    res.push_back(make_paint(span_from, w - 1, shadow.fg_color));
                span_open = 1'b0;
            end
            col_pos = 0;
            row_pos++;
            if (row_pos >= shadow.image_height)
            begin
                row_pos   = 0;
                image_end = 1'b1;
            end
        end
        else
            col_pos += 8;
        for (i = 0; i < res.size(); i++)
        begin
            p      = res[i];
            p.last = (i == res.size() - 1);
            p.done = p.last && image_end;
            paint_q.push_back(p);
        end
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Width or height: mostly small, sometimes zero or the largest value
    function automatic logic [15:0] pick_side(input int typical_max);
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1, 2:    return 16'd255;
            default: return 16'($urandom_range(1, typical_max));
        endcase
    endfunction

    function automatic logic [15:0] pick_origin();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hffff - 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one register write and hold it until taken; valid stays high
    task automatic write_reg(input mbr_pkg::reg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mbr_pkg::REG_FG_COLOR:     shadow.fg_color     = val;
            mbr_pkg::REG_CLEAR_COLOR:  shadow.clear_color  = val;
            mbr_pkg::REG_TRANSPARENT:  shadow.transparent  = val[0];
            mbr_pkg::REG_IMAGE_WIDTH:  shadow.image_width  = val[7:0];
            mbr_pkg::REG_IMAGE_HEIGHT: shadow.image_height = val[7:0];
            mbr_pkg::REG_ORIGIN_X:     shadow.origin_x     = val;
            mbr_pkg::REG_ORIGIN_Y:     shadow.origin_y     = val;
            default:                   ;
        endcase
    endtask

    // Wait until every byte is sent and every result seen, then let the
    // pipeline settle so that bytes without results have left it too
    task automatic drain();
        while (bitmap_q.size() != 0 || in_valid || paint_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expand_byte(bitmap_byte);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (bitmap_q.size() > 0)
                begin
                    in_valid    <= 1'b1;
                    bitmap_byte <= bitmap_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transaction, then choose the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (paint_q.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: xs=%h xe=%h y=%h c=%h last=%b done=%b",
                                 x_start, x_end, row_y, pixel_color, last_of_item, image_done);
                    mismatch_cnt++;
                end
                else
                begin
                    paint_t want;
                    want = paint_q.pop_front();
                    if (want.xs !== x_start || want.xe !== x_end || want.y !== row_y ||
                        want.color !== pixel_color || want.last !== last_of_item ||
                        want.done !== image_done)
                    begin
                        if (mismatch_cnt < 10)
                            $display({"result %0d mismatch: expected xs=%h xe=%h y=%h c=%h ",
                                      "last=%b done=%b, got xs=%h xe=%h y=%h c=%h last=%b done=%b"},
                                     result_cnt, want.xs, want.xe, want.y, want.color,
                                     want.last, want.done, x_start, x_end, row_y,
                                     pixel_color, last_of_item, image_done);
                        mismatch_cnt++;
                    end
                end
                result_cnt++;
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 80);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= (stall_tick % 4 == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int         sent;
        int         n;
        int         k;
        int         lo;
        int         hi;
        logic [7:0] b8;
        logic [7:0] ones;
        ones = 8'hff;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: opaque 8x8, all-set, all-clear and mixed bytes
        bitmap_q = '{8'hff, 8'h00, 8'ha5};
        drain();

        // Transparent, width 20, wrapping origin; height below current row
        write_reg(mbr_pkg::REG_FG_COLOR, 16'hf81f);
        write_reg(mbr_pkg::REG_CLEAR_COLOR, 16'h07e0);
        write_reg(mbr_pkg::REG_TRANSPARENT, 16'd1);
        write_reg(mbr_pkg::REG_IMAGE_WIDTH, 16'd20);
        write_reg(mbr_pkg::REG_IMAGE_HEIGHT, 16'd3);
        write_reg(mbr_pkg::REG_ORIGIN_X, 16'hfff8);
        write_reg(mbr_pkg::REG_ORIGIN_Y, 16'hffff);
        cfg_valid <= 1'b0;
        // span across bytes, row-end span with set padding, empty row
        bitmap_q = '{8'h0f, 8'hf0, 8'hff, 8'h00, 8'h00, 8'h00, 8'h81, 8'h3c, 8'h0f};
        drain();

        // Open a span past the new width, then shrink the width mid-row
        bitmap_q = '{8'h00, 8'h01};
        drain();
        write_reg(mbr_pkg::REG_IMAGE_WIDTH, 16'd10);
        cfg_valid <= 1'b0;
        bitmap_q = '{8'hff, 8'hff, 8'hc0};
        drain();

        // Pending span cleared by a switch to opaque
        bitmap_q = '{8'h01};
        drain();
        write_reg(mbr_pkg::REG_TRANSPARENT, 16'd0);
        cfg_valid <= 1'b0;
        bitmap_q = '{8'h80};
        drain();

        // Zero width and zero height
        write_reg(mbr_pkg::REG_IMAGE_WIDTH, 16'd0);
        write_reg(mbr_pkg::REG_IMAGE_HEIGHT, 16'd0);
        cfg_valid <= 1'b0;
        bitmap_q = '{8'hff, 8'h00};
        drain();

        // One-pixel bitmap in both modes
        write_reg(mbr_pkg::REG_IMAGE_WIDTH, 16'd1);
        write_reg(mbr_pkg::REG_IMAGE_HEIGHT, 16'd1);
        write_reg(mbr_pkg::REG_ORIGIN_X, 16'h0000);
        write_reg(mbr_pkg::REG_ORIGIN_Y, 16'h0000);
        cfg_valid <= 1'b0;
        bitmap_q = '{8'h80, 8'h7f};
        drain();
        write_reg(mbr_pkg::REG_TRANSPARENT, 16'd1);
        cfg_valid <= 1'b0;
        bitmap_q = '{8'h80};
        drain();

        // Largest bitmap with extreme colours and origin before random phases
        write_reg(mbr_pkg::REG_FG_COLOR, 16'h0000);
        write_reg(mbr_pkg::REG_CLEAR_COLOR, 16'hffff);
        write_reg(mbr_pkg::REG_IMAGE_WIDTH, 16'd255);
        write_reg(mbr_pkg::REG_IMAGE_HEIGHT, 16'd255);
        write_reg(mbr_pkg::REG_ORIGIN_X, 16'hffff);
        write_reg(mbr_pkg::REG_TRANSPARENT, 16'($urandom_range(0, 1)));
        cfg_valid <= 1'b0;

        // Random phases: reprogram a random subset, then a batch of bytes
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    write_reg(mbr_pkg::REG_FG_COLOR, pick_color());
                if ($urandom_range(0, 2) == 0)
                    write_reg(mbr_pkg::REG_CLEAR_COLOR, pick_color());
                if ($urandom_range(0, 2) != 0)
                    write_reg(mbr_pkg::REG_TRANSPARENT, 16'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 0)
                    write_reg(mbr_pkg::REG_IMAGE_WIDTH, pick_side(40));
                if ($urandom_range(0, 1) == 0)
                    write_reg(mbr_pkg::REG_IMAGE_HEIGHT, pick_side(5));
                if ($urandom_range(0, 3) == 0)
                    write_reg(mbr_pkg::REG_ORIGIN_X, pick_origin());
                if ($urandom_range(0, 3) == 0)
                    write_reg(mbr_pkg::REG_ORIGIN_Y, pick_origin());
                cfg_valid <= 1'b0;
            end
            n = $urandom_range(15, 45);
            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       b8 = 8'h00;
                    1:       b8 = 8'hff;
                    2:       b8 = 8'h80 >> $urandom_range(0, 7);
                    3, 4:
                    begin
                        // one contiguous run of set pixels
                        lo = $urandom_range(0, 7);
                        hi = $urandom_range(lo + 1, 8);
                        b8 = (ones >> lo) & ~(ones >> hi);
                    end
                    5:       b8 = $urandom_range(0, 1) ? 8'haa : 8'h55;
                    default: b8 = 8'($urandom);
                endcase
                bitmap_q.push_back(b8);
            end
            sent += n;
            drain();
        end

        if (mismatch_cnt == 0 && paint_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/mbr_pkg.sv
src/mbr_fifo.sv
src/mbr_front.sv
src/mbr_back.sv
src/mono_bitmap_to_rgb565_spans.sv
verif/mono_bitmap_to_rgb565_spans_tb.sv
